>>> hw/rtl/egg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package egg_pkg;

    // Datapath operations issued by the controller
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_INIT_WR,
        DP_ROW0,
        DP_ROW1,
        DP_J_START,
        DP_READ,
        DP_UPDATE,
        DP_WRITE
    } t_dp_op;

    typedef struct packed {
        logic trivial;   // answer is the floor count itself
        logic j_last;    // column index has reached the floor count
        logic search_on; // binary search still has a range
        logic egg_last;  // current row is the last egg count
    } t_dp_sts;

endpackage

`default_nettype wire

>>> hw/rtl/egg_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module egg_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  egg_pkg::t_dp_sts     i_sts,
    output egg_pkg::t_dp_op      o_op,
    output logic                 o_busy,
    output logic                 o_valid
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INIT,
        S_ROW0,
        S_ROW1,
        S_JST,
        S_RD,
        S_CMP,
        S_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   n_busy;
    logic   r_valid;
    logic   n_valid;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        n_valid = 1'b0;
        o_op    = egg_pkg::DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_op    = egg_pkg::DP_LOAD;
                    n_state = S_CHECK;
                    n_busy  = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_sts.trivial) begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_valid = 1'b1;
                end else begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                o_op = egg_pkg::DP_INIT_WR;
                if (i_sts.j_last) begin
                    n_state = S_ROW0;
                end
            end
            S_ROW0: begin
                o_op    = egg_pkg::DP_ROW0;
                n_state = S_ROW1;
            end
            S_ROW1: begin
                o_op    = egg_pkg::DP_ROW1;
                n_state = S_JST;
            end
            S_JST: begin
                o_op    = egg_pkg::DP_J_START;
                n_state = S_RD;
            end
            S_RD: begin
                if (i_sts.search_on) begin
                    o_op    = egg_pkg::DP_READ;
                    n_state = S_CMP;
                end else begin
                    n_state = S_WR;
                end
            end
            S_CMP: begin
                o_op    = egg_pkg::DP_UPDATE;
                n_state = S_RD;
            end
            S_WR: begin
                o_op = egg_pkg::DP_WRITE;
                if (!i_sts.j_last) begin
                    n_state = S_JST;
                end else if (!i_sts.egg_last) begin
                    n_state = S_ROW0;
                end else begin
                    n_state = S_IDLE;
                    n_busy  = 1'b0;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
            r_valid <= n_valid;
        end
    end

    assign o_busy  = r_busy;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

>>> hw/rtl/egg_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module egg_dpath #(
    parameter int MAX_EGGS   = 16,
    parameter int MAX_FLOORS = 1024
) (
    input  wire logic            i_clk,
    input  wire logic [4:0]      i_eggs,
    input  wire logic [10:0]     i_floors,
    input  egg_pkg::t_dp_op      i_op,
    output egg_pkg::t_dp_sts     o_sts,
    output logic [10:0]          o_min_drops
);

    localparam int DEPTH = MAX_FLOORS + 1;
    localparam int AW    = $clog2(MAX_FLOORS + 1);
    localparam int VW    = $clog2(MAX_FLOORS + 2);
    localparam int LW    = AW + 1;
    localparam int EW    = $clog2(MAX_EGGS + 1);
    localparam int EXW   = (EW > 5) ? EW : 5;
    localparam int FXW   = (AW > 11) ? AW : 11;

    logic [VW-1:0] mem0 [0:DEPTH-1];
    logic [VW-1:0] mem1 [0:DEPTH-1];
    logic [VW-1:0] r_q0;
    logic [VW-1:0] r_q1;

    logic [EW-1:0] r_eggs;
    logic [EW-1:0] r_e;
    logic [AW-1:0] r_floors;
    logic [AW-1:0] r_j;
    logic [LW-1:0] r_lo;
    logic [LW-1:0] r_hi;
    logic [VW-1:0] r_best;
    logic [VW-1:0] r_res;
    logic          r_sel;

    logic [EXW-1:0] eggs_x;
    logic [FXW-1:0] floors_x;
    logic [EW-1:0]  eggs_c;
    logic [AW-1:0]  floors_c;
    logic [LW:0]    mid_sum;
    logic [LW-1:0]  mid;
    logic [AW-1:0]  brk_addr;
    logic [AW-1:0]  srv_addr;
    logic [VW-1:0]  brk;
    logic [VW-1:0]  srv;
    logic [VW-1:0]  cost;
    logic           wr_en;
    logic           wr_mem;
    logic [AW-1:0]  wr_addr;
    logic [VW-1:0]  wr_data;

    // Clamp the query into the table range
    always_comb begin
        eggs_x   = EXW'(i_eggs);
        floors_x = FXW'(i_floors);
        if (eggs_x == '0) begin
            eggs_c = EW'(1);
        end else if (eggs_x > EXW'(MAX_EGGS)) begin
            eggs_c = EW'(MAX_EGGS);
        end else begin
            eggs_c = EW'(eggs_x);
        end
        if (floors_x > FXW'(MAX_FLOORS)) begin
            floors_c = AW'(MAX_FLOORS);
        end else begin
            floors_c = AW'(floors_x);
        end
    end

    // Probe floor and the two table entries it needs
    assign mid_sum  = (LW + 1)'(r_lo) + (LW + 1)'(r_hi);
    assign mid      = LW'(mid_sum >> 1);
    assign brk_addr = AW'(mid - LW'(1));
    assign srv_addr = AW'(LW'(r_j) - mid);

    // Row roles swap per egg count: r_sel names the memory holding the previous row
    assign brk  = r_sel ? r_q1 : r_q0;
    assign srv  = r_sel ? r_q0 : r_q1;
    assign cost = VW'(1) + ((brk > srv) ? brk : srv);

    always_comb begin
        wr_en   = 1'b0;
        wr_mem  = ~r_sel;
        wr_addr = r_j;
        wr_data = r_best;
        case (i_op)
            egg_pkg::DP_INIT_WR: begin
                wr_en   = 1'b1;
                wr_mem  = r_sel;
                wr_data = VW'(r_j);
            end
            egg_pkg::DP_ROW0: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '0;
            end
            egg_pkg::DP_ROW1: begin
                wr_en   = 1'b1;
                wr_addr = AW'(1);
                wr_data = VW'(1);
            end
            egg_pkg::DP_WRITE: begin
                wr_en = 1'b1;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && !wr_mem) begin
            mem0[wr_addr] <= wr_data;
        end
        r_q0 <= mem0[r_sel ? srv_addr : brk_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && wr_mem) begin
            mem1[wr_addr] <= wr_data;
        end
        r_q1 <= mem1[r_sel ? brk_addr : srv_addr];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            egg_pkg::DP_LOAD: begin
                r_eggs   <= eggs_c;
                r_floors <= floors_c;
                r_e      <= EW'(2);
                r_j      <= '0;
                r_sel    <= 1'b0;
                r_res    <= VW'(floors_c);
            end
            egg_pkg::DP_INIT_WR: begin
                r_j <= r_j + AW'(1);
            end
            egg_pkg::DP_ROW1: begin
                r_j <= AW'(2);
            end
            egg_pkg::DP_J_START: begin
                r_lo   <= LW'(1);
                r_hi   <= LW'(r_j);
                r_best <= '1;
            end
            egg_pkg::DP_UPDATE: begin
                if (brk < srv) begin
                    r_lo <= mid + LW'(1);
                end else begin
                    r_hi <= mid - LW'(1);
                end
                if (cost < r_best) begin
                    r_best <= cost;
                end
            end
            egg_pkg::DP_WRITE: begin
                r_res <= r_best;
                r_j   <= r_j + AW'(1);
                // Finished row becomes the previous row
                if (r_j == r_floors && r_e != r_eggs) begin
                    r_sel <= ~r_sel;
                    r_e   <= r_e + EW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_sts.trivial   = (r_floors <= AW'(1)) || (r_eggs <= EW'(1));
    assign o_sts.j_last    = (r_j == r_floors);
    assign o_sts.search_on = (r_lo <= r_hi);
    assign o_sts.egg_last  = (r_e == r_eggs);
    assign o_min_drops     = 11'(r_res);

endmodule

`default_nettype wire

>>> hw/rtl/egg_drop_min_trials.sv
// Channel   Ports                         Handshake
// query     i_eggs, i_floors              taken when start is high and busy is low
// answer    o_min_drops                   one cycle with o_valid high, no stall
//
// One query at a time; busy stays high from the cycle after start until o_valid.
// Sequence: for one egg or at most one floor o_valid follows the check of the query; otherwise
// the first row is built over floors 0..floors, then each further egg writes columns 0 and 1 and
// searches columns j = 2..floors with at most p = floor(log2(j)) + 1 probes each,
// the binary search doing one table read pair and one compare per probe.
// Every table entry that a query reads was written earlier by that query; no clear pass.
// Reset is synchronous and clears the controller only.
`timescale 1ns / 1ps
`default_nettype none

module egg_drop_min_trials #(
    parameter int MAX_EGGS   = 16,
    parameter int MAX_FLOORS = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    input  wire logic [4:0]  i_eggs,
    input  wire logic [10:0] i_floors,
    output logic             busy,
    output logic             o_valid,
    output logic [10:0]      o_min_drops
);

    egg_pkg::t_dp_op  op;
    egg_pkg::t_dp_sts sts;

    egg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_op    (op),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    egg_dpath #(
        .MAX_EGGS   (MAX_EGGS),
        .MAX_FLOORS (MAX_FLOORS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_eggs      (i_eggs),
        .i_floors    (i_floors),
        .i_op        (op),
        .o_sts       (sts),
        .o_min_drops (o_min_drops)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_valid_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy && $past(busy)))
        else $error("answer strobe not at end of a busy period");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("answer strobe longer than one cycle");

endmodule

`default_nettype wire
